FILE: rtl/dta_pkg.sv
// Package for the descriptor table allocator: action and status codes,
// controller states and the command and status words between controller and datapath.
// No dependencies.
package dta_pkg;

    localparam logic [7:0] REFS_MAX = 8'd255;

    typedef enum logic [3:0] {
        ACT_CREATE  = 4'd0,
        ACT_TAKE    = 4'd1,
        ACT_DROP    = 4'd2,
        ACT_INSTALL = 4'd3,
        ACT_CLOSE   = 4'd4,
        ACT_DUP     = 4'd5,
        ACT_LOOKUP  = 4'd6,
        ACT_GETCX   = 4'd7,
        ACT_SETCX   = 4'd8,
        ACT_RELALL  = 4'd9
    } act_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_FULL  = 2'd2,
        ST_BADF  = 2'd3
    } st_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_REFS_CHK,
        S_CAP_D,
        S_CLOSE_R,
        S_DUP_R,
        S_DUP_E,
        S_DUP_ER,
        S_SCAN,
        S_SCAN_D,
        S_SCAN_R,
        S_SCAN_PUSH,
        S_SCAN_END,
        S_FIN
    } state_t;

    // Slot address for a read of the slot description store.
    typedef enum logic [1:0] {
        DS_FD,
        DS_NFD,
        DS_SCAN
    } dsel_t;

    // Address for a read of the count store.
    typedef enum logic {
        RS_ID,
        RS_DRD
    } rsel_t;

    // A description id held in a register.
    typedef enum logic [1:0] {
        DR_ID,
        DR_D,
        DR_E
    } dref_t;

    typedef enum logic [1:0] {
        OP_SET1,
        OP_INC,
        OP_DEC
    } rop_t;

    typedef enum logic [1:0] {
        V_FREE,
        V_NFD,
        V_CX
    } vsel_t;

    typedef struct packed {
        logic  load;
        logic  desc_rd;
        dsel_t desc_rsel;
        logic  cap_d;
        logic  cap_e;
        logic  refs_rd;
        rsel_t refs_rsel;
        logic  refs_wr;
        dref_t refs_wsel;
        rop_t  refs_op;
        logic  slot_set;
        logic  slot_set_nfd;
        dref_t slot_set_src;
        logic  slot_clr;
        logic  slot_clr_scan;
        logic  set_cx;
        logic  st_we;
        st_t   st;
        logic  val_we;
        vsel_t val_sel;
        logic  set_found;
        logic  rel_we;
        dref_t rel_sel;
        logic  scan_clr;
        logic  scan_inc;
        logic  pend_load;
        logic  pend_clr;
        logic  push;
        logic  push_pend;
        logic  push_last;
    } cmd_t;

    typedef struct packed {
        act_t act;
        logic fd_ok;
        logic nfd_in;
        logic nfd_valid;
        logic same_fd;
        logic id_ok;
        logic min_neg;
        logic free_found;
        logic refs_zero;
        logic refs_max;
        logic refs_one;
        logic scan_done;
        logic scan_valid;
        logic out_free;
        logic pend_valid;
    } stat_t;

endpackage

FILE: rtl/dta_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module dta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/dta_ctrl.sv
// Controller state machine of the descriptor table allocator.
// Depends on dta_pkg; drives the datapath through a command word.
module dta_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  dta_pkg::stat_t stat,
    output dta_pkg::cmd_t  cmd
);
    import dta_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.act)
                    ACT_CREATE, ACT_TAKE, ACT_DROP:
                        state_next = stat.id_ok ? S_REFS_CHK : S_FIN;
                    ACT_INSTALL:
                        state_next = (stat.id_ok && !stat.min_neg) ? S_REFS_CHK : S_FIN;
                    ACT_CLOSE, ACT_LOOKUP:
                        state_next = stat.fd_ok ? S_CAP_D : S_FIN;
                    ACT_DUP:
                        state_next = (stat.fd_ok && stat.nfd_in && !stat.same_fd) ?
                                     S_CAP_D : S_FIN;
                    ACT_RELALL:
                        state_next = S_SCAN;
                    default:
                        state_next = S_FIN;
                endcase
            end
            S_REFS_CHK:
                state_next = S_FIN;
            S_CAP_D:
            begin
                case (stat.act)
                    ACT_CLOSE: state_next = S_CLOSE_R;
                    ACT_DUP:   state_next = S_DUP_R;
                    default:   state_next = S_FIN;
                endcase
            end
            S_CLOSE_R:
                state_next = S_FIN;
            S_DUP_R:
            begin
                if (stat.refs_zero || stat.refs_max || !stat.nfd_valid)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DUP_E;
                end
            end
            S_DUP_E:
                state_next = S_DUP_ER;
            S_DUP_ER:
                state_next = S_FIN;
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_SCAN_END;
                end
                else if (stat.scan_valid)
                begin
                    state_next = S_SCAN_D;
                end
            end
            S_SCAN_D:
                state_next = S_SCAN_R;
            S_SCAN_R:
                state_next = (!stat.refs_zero && stat.refs_one) ? S_SCAN_PUSH : S_SCAN;
            S_SCAN_PUSH:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN_END, S_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
                cmd.load = in_valid;
            S_DISPATCH:
            begin
                case (stat.act)
                    ACT_CREATE, ACT_TAKE, ACT_DROP:
                    begin
                        if (stat.id_ok)
                        begin
                            cmd.refs_rd = 1'b1;
                            cmd.refs_rsel = RS_ID;
                        end
                        else
                        begin
                            cmd.st_we = 1'b1;
                            cmd.st = ST_INVAL;
                        end
                    end
                    ACT_INSTALL:
                    begin
                        if (stat.id_ok && !stat.min_neg)
                        begin
                            cmd.refs_rd = 1'b1;
                            cmd.refs_rsel = RS_ID;
                        end
                        else
                        begin
                            cmd.st_we = 1'b1;
                            cmd.st = ST_INVAL;
                        end
                    end
                    ACT_CLOSE:
                    begin
                        if (stat.fd_ok)
                        begin
                            cmd.desc_rd = 1'b1;
                            cmd.desc_rsel = DS_FD;
                        end
                        else
                        begin
                            cmd.st_we = 1'b1;
                            cmd.st = ST_BADF;
                        end
                    end
                    ACT_LOOKUP:
                    begin
                        // A miss answers ok with nothing found.
                        cmd.desc_rd = stat.fd_ok;
                        cmd.desc_rsel = DS_FD;
                    end
                    ACT_DUP:
                    begin
                        if (!stat.fd_ok || !stat.nfd_in)
                        begin
                            cmd.st_we = 1'b1;
                            cmd.st = ST_BADF;
                        end
                        else if (stat.same_fd)
                        begin
                            cmd.val_we = 1'b1;
                            cmd.val_sel = V_NFD;
                        end
                        else
                        begin
                            cmd.desc_rd = 1'b1;
                            cmd.desc_rsel = DS_FD;
                        end
                    end
                    ACT_GETCX:
                    begin
                        if (stat.fd_ok)
                        begin
                            cmd.val_we = 1'b1;
                            cmd.val_sel = V_CX;
                        end
                        else
                        begin
                            cmd.st_we = 1'b1;
                            cmd.st = ST_BADF;
                        end
                    end
                    ACT_SETCX:
                    begin
                        if (stat.fd_ok)
                        begin
                            cmd.set_cx = 1'b1;
                        end
                        else
                        begin
                            cmd.st_we = 1'b1;
                            cmd.st = ST_BADF;
                        end
                    end
                    ACT_RELALL:
                        cmd.scan_clr = 1'b1;
                    default:
                    begin
                        cmd.st_we = 1'b1;
                        cmd.st = ST_INVAL;
                    end
                endcase
            end
            S_REFS_CHK:
            begin
                cmd.refs_wsel = DR_ID;
                case (stat.act)
                    ACT_CREATE:
                    begin
                        if (!stat.refs_zero)
                        begin
                            cmd.st_we = 1'b1;
                            cmd.st = ST_INVAL;
                        end
                        else
                        begin
                            cmd.refs_wr = 1'b1;
                            cmd.refs_op = OP_SET1;
                        end
                    end
                    ACT_TAKE:
                    begin
                        if (stat.refs_zero || stat.refs_max)
                        begin
                            cmd.st_we = 1'b1;
                            cmd.st = ST_INVAL;
                        end
                        else
                        begin
                            cmd.refs_wr = 1'b1;
                            cmd.refs_op = OP_INC;
                        end
                    end
                    ACT_DROP:
                    begin
                        if (stat.refs_zero)
                        begin
                            cmd.st_we = 1'b1;
                            cmd.st = ST_INVAL;
                        end
                        else
                        begin
                            cmd.refs_wr = 1'b1;
                            cmd.refs_op = OP_DEC;
                            cmd.rel_we = stat.refs_one;
                            cmd.rel_sel = DR_ID;
                        end
                    end
                    ACT_INSTALL:
                    begin
                        if (stat.refs_zero || stat.refs_max)
                        begin
                            cmd.st_we = 1'b1;
                            cmd.st = ST_INVAL;
                        end
                        else if (!stat.free_found)
                        begin
                            cmd.st_we = 1'b1;
                            cmd.st = ST_FULL;
                        end
                        else
                        begin
                            cmd.refs_wr = 1'b1;
                            cmd.refs_op = OP_INC;
                            cmd.slot_set = 1'b1;
                            cmd.slot_set_nfd = 1'b0;
                            cmd.slot_set_src = DR_ID;
                            cmd.val_we = 1'b1;
                            cmd.val_sel = V_FREE;
                        end
                    end
                    default:
                    begin
                        cmd.st_we = 1'b1;
                        cmd.st = ST_INVAL;
                    end
                endcase
            end
            S_CAP_D:
            begin
                cmd.cap_d = 1'b1;
                case (stat.act)
                    ACT_LOOKUP:
                        cmd.set_found = 1'b1;
                    ACT_CLOSE:
                    begin
                        cmd.slot_clr = 1'b1;
                        cmd.slot_clr_scan = 1'b0;
                        cmd.refs_rd = 1'b1;
                        cmd.refs_rsel = RS_DRD;
                    end
                    ACT_DUP:
                    begin
                        cmd.refs_rd = 1'b1;
                        cmd.refs_rsel = RS_DRD;
                    end
                    default:
                        cmd.cap_d = 1'b1;
                endcase
            end
            S_CLOSE_R:
            begin
                // A stale slot leaves its zero count alone.
                cmd.refs_wr = !stat.refs_zero;
                cmd.refs_wsel = DR_D;
                cmd.refs_op = OP_DEC;
                cmd.rel_we = !stat.refs_zero && stat.refs_one;
                cmd.rel_sel = DR_D;
            end
            S_DUP_R:
            begin
                if (stat.refs_zero || stat.refs_max)
                begin
                    cmd.st_we = 1'b1;
                    cmd.st = ST_INVAL;
                end
                else
                begin
                    cmd.refs_wr = 1'b1;
                    cmd.refs_wsel = DR_D;
                    cmd.refs_op = OP_INC;
                    cmd.val_we = 1'b1;
                    cmd.val_sel = V_NFD;
                    if (stat.nfd_valid)
                    begin
                        cmd.desc_rd = 1'b1;
                        cmd.desc_rsel = DS_NFD;
                    end
                    else
                    begin
                        cmd.slot_set = 1'b1;
                        cmd.slot_set_nfd = 1'b1;
                        cmd.slot_set_src = DR_D;
                    end
                end
            end
            S_DUP_E:
            begin
                // Holds the increment above if both slots share a description.
                cmd.cap_e = 1'b1;
                cmd.refs_rd = 1'b1;
                cmd.refs_rsel = RS_DRD;
            end
            S_DUP_ER:
            begin
                cmd.refs_wr = !stat.refs_zero;
                cmd.refs_wsel = DR_E;
                cmd.refs_op = OP_DEC;
                cmd.rel_we = !stat.refs_zero && stat.refs_one;
                cmd.rel_sel = DR_E;
                cmd.slot_set = 1'b1;
                cmd.slot_set_nfd = 1'b1;
                cmd.slot_set_src = DR_D;
            end
            S_SCAN:
            begin
                if (!stat.scan_done)
                begin
                    if (stat.scan_valid)
                    begin
                        cmd.slot_clr = 1'b1;
                        cmd.slot_clr_scan = 1'b1;
                        cmd.desc_rd = 1'b1;
                        cmd.desc_rsel = DS_SCAN;
                    end
                    else
                    begin
                        cmd.scan_inc = 1'b1;
                    end
                end
            end
            S_SCAN_D:
            begin
                cmd.cap_d = 1'b1;
                cmd.refs_rd = 1'b1;
                cmd.refs_rsel = RS_DRD;
            end
            S_SCAN_R:
            begin
                cmd.refs_wr = !stat.refs_zero;
                cmd.refs_wsel = DR_D;
                cmd.refs_op = OP_DEC;
                cmd.scan_inc = !(!stat.refs_zero && stat.refs_one);
            end
            S_SCAN_PUSH:
            begin
                // One release is held back so that the final one can carry last.
                if (!stat.pend_valid)
                begin
                    cmd.pend_load = 1'b1;
                    cmd.scan_inc = 1'b1;
                end
                else if (stat.out_free)
                begin
                    cmd.push = 1'b1;
                    cmd.push_pend = 1'b1;
                    cmd.pend_load = 1'b1;
                    cmd.scan_inc = 1'b1;
                end
            end
            S_SCAN_END:
            begin
                if (stat.out_free)
                begin
                    cmd.push = 1'b1;
                    cmd.push_pend = stat.pend_valid;
                    cmd.push_last = 1'b1;
                    cmd.pend_clr = 1'b1;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.push = 1'b1;
                    cmd.push_last = 1'b1;
                end
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

FILE: rtl/dta_datapath.sv
// Datapath of the descriptor table allocator: slot flags, the slot description
// and count stores, the lowest-free search and the result registers. Uses dta_pkg and dta_ram.
module dta_datapath #(
    parameter int SLOTS = 64,
    parameter int DESCS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [3:0]           action,
    input  logic signed [7:0]    fd,
    input  logic signed [7:0]    new_fd,
    input  logic [5:0]           desc_id,
    input  logic                 flag,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [6:0]           value,
    output logic [5:0]           found_desc,
    output logic                 found,
    output logic                 released,
    output logic [5:0]           released_desc,
    output logic                 last,
    input  dta_pkg::cmd_t        cmd,
    output dta_pkg::stat_t       stat
);
    import dta_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int DW = $clog2(DESCS);

    act_t             act_reg;
    logic [7:0]       fd_reg;
    logic [7:0]       nfd_reg;
    logic [5:0]       id_reg;
    logic             flag_reg;

    logic [SLOTS-1:0] slot_valid_reg;
    logic [SLOTS-1:0] slot_cx_reg;
    logic [DESCS-1:0] refs_live_reg;
    logic             refs_rlive_reg;

    logic [DW-1:0]    d_reg;
    logic [DW-1:0]    e_reg;
    logic [SW:0]      scan_reg;
    logic             pend_valid_reg;
    logic [DW-1:0]    pend_desc_reg;

    st_t              res_st_reg;
    logic [6:0]       res_val_reg;
    logic [5:0]       res_fdesc_reg;
    logic             res_found_reg;
    logic             res_rel_reg;
    logic [5:0]       res_reld_reg;

    logic             out_valid_reg;
    st_t              out_st_reg;
    logic [6:0]       out_val_reg;
    logic [5:0]       out_fdesc_reg;
    logic             out_found_reg;
    logic             out_rel_reg;
    logic [5:0]       out_reld_reg;
    logic             out_last_reg;

    logic [SW-1:0]    fd_idx;
    logic [SW-1:0]    nfd_idx;
    logic [SW-1:0]    scan_idx;
    logic [DW-1:0]    id_idx;
    logic             fd_in;
    logic             free_found;
    logic [SW-1:0]    free_idx;

    logic             desc_we;
    logic [SW-1:0]    desc_waddr;
    logic [DW-1:0]    desc_wdata;
    logic [SW-1:0]    desc_raddr;
    logic [DW-1:0]    desc_rdata;

    logic [DW-1:0]    refs_waddr;
    logic [7:0]       refs_wdata;
    logic [DW-1:0]    refs_raddr;
    logic [7:0]       refs_rdata;
    logic [7:0]       refs_val;
    logic [DW-1:0]    rel_src;
    logic             out_free;

    assign fd_idx   = fd_reg[SW-1:0];
    assign nfd_idx  = nfd_reg[SW-1:0];
    assign scan_idx = scan_reg[SW-1:0];
    assign id_idx   = id_reg[DW-1:0];
    assign fd_in    = !fd_reg[7] && (fd_reg[6:0] < 7'(SLOTS));
    assign out_free = !out_valid_reg || !out_stall;

    // Lowest free slot at or above the minimum.
    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i] && (7'(i) >= fd_reg[6:0]))
            begin
                free_found = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    assign desc_we    = cmd.slot_set;
    assign desc_waddr = cmd.slot_set_nfd ? nfd_idx : free_idx;
    assign desc_wdata = (cmd.slot_set_src == DR_ID) ? id_idx : d_reg;

    always_comb
    begin
        case (cmd.desc_rsel)
            DS_FD:   desc_raddr = fd_idx;
            DS_NFD:  desc_raddr = nfd_idx;
            DS_SCAN: desc_raddr = scan_idx;
            default: desc_raddr = fd_idx;
        endcase
    end

    dta_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_desc_ram (
        .clk   (clk),
        .we    (desc_we),
        .waddr (desc_waddr),
        .wdata (desc_wdata),
        .re    (cmd.desc_rd),
        .raddr (desc_raddr),
        .rdata (desc_rdata)
    );

    assign refs_raddr = (cmd.refs_rsel == RS_ID) ? id_idx : desc_rdata;
    assign refs_val   = refs_rlive_reg ? refs_rdata : 8'd0;

    always_comb
    begin
        case (cmd.refs_wsel)
            DR_ID:   refs_waddr = id_idx;
            DR_D:    refs_waddr = d_reg;
            DR_E:    refs_waddr = e_reg;
            default: refs_waddr = id_idx;
        endcase
    end

    always_comb
    begin
        case (cmd.refs_op)
            OP_SET1: refs_wdata = 8'd1;
            OP_INC:  refs_wdata = refs_val + 8'd1;
            OP_DEC:  refs_wdata = refs_val - 8'd1;
            default: refs_wdata = refs_val;
        endcase
    end

    dta_ram #(
        .WIDTH (8),
        .DEPTH (DESCS)
    ) u_refs_ram (
        .clk   (clk),
        .we    (cmd.refs_wr),
        .waddr (refs_waddr),
        .wdata (refs_wdata),
        .re    (cmd.refs_rd),
        .raddr (refs_raddr),
        .rdata (refs_rdata)
    );

    always_comb
    begin
        case (cmd.rel_sel)
            DR_ID:   rel_src = id_idx;
            DR_D:    rel_src = d_reg;
            DR_E:    rel_src = e_reg;
            default: rel_src = id_idx;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            slot_cx_reg    <= '0;
            refs_live_reg  <= '0;
            refs_rlive_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            scan_reg       <= '0;
        end
        else
        begin
            if (cmd.slot_set)
            begin
                slot_valid_reg[desc_waddr] <= 1'b1;
                slot_cx_reg[desc_waddr]    <= flag_reg;
            end
            if (cmd.slot_clr)
            begin
                slot_valid_reg[cmd.slot_clr_scan ? scan_idx : fd_idx] <= 1'b0;
                slot_cx_reg[cmd.slot_clr_scan ? scan_idx : fd_idx]    <= 1'b0;
            end
            if (cmd.set_cx)
            begin
                slot_cx_reg[fd_idx] <= flag_reg;
            end
            if (cmd.refs_wr)
            begin
                refs_live_reg[refs_waddr] <= 1'b1;
            end
            if (cmd.refs_rd)
            begin
                refs_rlive_reg <= refs_live_reg[refs_raddr];
            end
            if (cmd.scan_clr)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.pend_clr)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg       <= act_t'(action);
            fd_reg        <= fd;
            nfd_reg       <= new_fd;
            id_reg        <= desc_id;
            flag_reg      <= flag;
            res_st_reg    <= ST_OK;
            res_val_reg   <= '0;
            res_fdesc_reg <= '0;
            res_found_reg <= 1'b0;
            res_rel_reg   <= 1'b0;
            res_reld_reg  <= '0;
        end
        if (cmd.st_we)
        begin
            res_st_reg <= cmd.st;
        end
        if (cmd.val_we)
        begin
            case (cmd.val_sel)
                V_FREE:  res_val_reg <= 7'(free_idx);
                V_NFD:   res_val_reg <= nfd_reg[6:0];
                V_CX:    res_val_reg <= 7'(slot_cx_reg[fd_idx]);
                default: res_val_reg <= '0;
            endcase
        end
        if (cmd.set_found)
        begin
            res_found_reg <= 1'b1;
            res_fdesc_reg <= 6'(desc_rdata);
        end
        if (cmd.rel_we)
        begin
            res_rel_reg  <= 1'b1;
            res_reld_reg <= 6'(rel_src);
        end
        if (cmd.cap_d)
        begin
            d_reg <= desc_rdata;
        end
        if (cmd.cap_e)
        begin
            e_reg <= desc_rdata;
        end
        if (cmd.pend_load)
        begin
            pend_desc_reg <= d_reg;
        end
        if (cmd.push)
        begin
            out_last_reg <= cmd.push_last;
            if (cmd.push_pend)
            begin
                out_st_reg    <= ST_OK;
                out_val_reg   <= '0;
                out_fdesc_reg <= '0;
                out_found_reg <= 1'b0;
                out_rel_reg   <= 1'b1;
                out_reld_reg  <= 6'(pend_desc_reg);
            end
            else
            begin
                out_st_reg    <= res_st_reg;
                out_val_reg   <= res_val_reg;
                out_fdesc_reg <= res_fdesc_reg;
                out_found_reg <= res_found_reg;
                out_rel_reg   <= res_rel_reg;
                out_reld_reg  <= res_reld_reg;
            end
        end
    end

    assign stat.act        = act_reg;
    assign stat.fd_ok      = fd_in && slot_valid_reg[fd_idx];
    assign stat.nfd_in     = !nfd_reg[7] && (nfd_reg[6:0] < 7'(SLOTS));
    assign stat.nfd_valid  = slot_valid_reg[nfd_idx];
    assign stat.same_fd    = (fd_reg == nfd_reg);
    assign stat.id_ok      = ({1'b0, id_reg} < 7'(DESCS));
    assign stat.min_neg    = fd_reg[7];
    assign stat.free_found = free_found;
    assign stat.refs_zero  = (refs_val == 8'd0);
    assign stat.refs_max   = (refs_val == REFS_MAX);
    assign stat.refs_one   = (refs_val == 8'd1);
    assign stat.scan_done  = (scan_reg == (SW + 1)'(SLOTS));
    assign stat.scan_valid = slot_valid_reg[scan_idx];
    assign stat.out_free   = out_free;
    assign stat.pend_valid = pend_valid_reg;

    assign out_valid     = out_valid_reg;
    assign status        = out_st_reg;
    assign value         = out_val_reg;
    assign found_desc    = out_fdesc_reg;
    assign found         = out_found_reg;
    assign released      = out_rel_reg;
    assign released_desc = out_reld_reg;
    assign last          = out_last_reg;

endmodule

FILE: rtl/descriptor_table_allocator.sv
// Descriptor table allocator, top level: the controller and the datapath.
// Depends on dta_pkg, dta_ctrl, dta_datapath and dta_ram.
//
// One word is taken at a time; in_stall is high from acceptance until the
// last result word has been loaded into the output register. Lookups and
// counts go through the registered reads of the slot description and count
// RAMs, one after the other; duplicate over an occupied slot is the longest
// single result. Release all walks every slot. The lowest-free search of
// install is a combinational priority encoder over the slot flags. No
// clearing pass is needed after reset: the counts carry one live bit each.
module descriptor_table_allocator #(
    parameter int SLOTS = 64,
    parameter int DESCS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [3:0]        action,
    input  logic signed [7:0] fd,
    input  logic signed [7:0] new_fd,
    input  logic [5:0]        desc_id,
    input  logic              flag,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [6:0]        value,
    output logic [5:0]        found_desc,
    output logic              found,
    output logic              released,
    output logic [5:0]        released_desc,
    output logic              last
);
    import dta_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    dta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    dta_datapath #(
        .SLOTS (SLOTS),
        .DESCS (DESCS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .action        (action),
        .fd            (fd),
        .new_fd        (new_fd),
        .desc_id       (desc_id),
        .flag          (flag),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .value         (value),
        .found_desc    (found_desc),
        .found         (found),
        .released      (released),
        .released_desc (released_desc),
        .last          (last),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule
